// File: hw/rtl/lprtr_pkg.sv
`default_nettype none
package lprtr_pkg;

    localparam int COORD_W   = 18;
    localparam int INTEN_W   = 8;
    localparam int CORDIC_N  = 20;
    localparam int CORDIC_W  = 46;
    localparam int ANG_W     = 32;
    localparam int NUM_CFG   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 18;
    localparam int NUM_RINGS_DEF   = 16;
    localparam int NUM_FIRINGS_DEF = 1824;
    localparam int RING_W    = 4;
    localparam int FIRING_W  = 11;
    localparam int TIME_W    = 27;
    localparam logic signed [ANG_W-1:0] DEG90_FINE = 32'sd23040000;
    localparam logic signed [31:0] FULL_TURN = 32'sd360000;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEV_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AZ_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_T   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_T   = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [INTEN_W-1:0]        inten;
        logic                      keep;
        logic                      fstart;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQRT, ST_EL_INIT, ST_EL_RUN, ST_RING_DIV, ST_RING_CHK,
        ST_AZ_INIT, ST_AZ_RUN, ST_FIRE_DIV, ST_FIRE_CHK, ST_TIME, ST_EMIT
    } state_t;

    function automatic logic signed [ANG_W-1:0] atan_fine(input logic [4:0] i);
        case (i)
            5'd0:  atan_fine = 32'sd11520000;
            5'd1:  atan_fine = 32'sd6800653;
            5'd2:  atan_fine = 32'sd3593278;
            5'd3:  atan_fine = 32'sd1824004;
            5'd4:  atan_fine = 32'sd915542;
            5'd5:  atan_fine = 32'sd458217;
            5'd6:  atan_fine = 32'sd229164;
            5'd7:  atan_fine = 32'sd114589;
            5'd8:  atan_fine = 32'sd57295;
            5'd9:  atan_fine = 32'sd28648;
            5'd10: atan_fine = 32'sd14324;
            5'd11: atan_fine = 32'sd7162;
            5'd12: atan_fine = 32'sd3581;
            5'd13: atan_fine = 32'sd1790;
            5'd14: atan_fine = 32'sd895;
            5'd15: atan_fine = 32'sd448;
            5'd16: atan_fine = 32'sd224;
            5'd17: atan_fine = 32'sd112;
            5'd18: atan_fine = 32'sd56;
            5'd19: atan_fine = 32'sd28;
            default: atan_fine = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lprtr_front.sv
`default_nettype none
// Accept points and classify them: keep flag marks valid, non-zero coordinates.
module lprtr_front
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [lprtr_pkg::COORD_W-1:0] x_pos,
    input  wire logic signed [lprtr_pkg::COORD_W-1:0] y_pos,
    input  wire logic signed [lprtr_pkg::COORD_W-1:0] z_pos,
    input  wire logic [lprtr_pkg::INTEN_W-1:0]        intensity,
    input  wire logic                                coord_valid,
    input  wire logic                                frame_start,
    output lprtr_pkg::item_t                         q_item,
    output logic                                     q_valid,
    input  wire logic                                q_take
);
    // two-entry queue toward the back part
    lprtr_pkg::item_t mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       acc;
    lprtr_pkg::item_t cls;

    assign full    = (cnt_reg == 2'd2);
    assign acc     = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem[rp_reg];

    // classify incoming transaction
    always_comb
    begin
        cls.x      = x_pos;
        cls.y      = y_pos;
        cls.z      = z_pos;
        cls.inten  = intensity;
        cls.fstart = frame_start;
        cls.keep   = coord_valid && !(x_pos == '0 && y_pos == '0 && z_pos == '0);
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            mem[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (acc)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_take && q_valid)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(acc) - 2'(q_take && q_valid);
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/lprtr_back.sv
`default_nettype none
// Sequence one point: sqrt, elevation CORDIC, ring divide and check, azimuth
// CORDIC, firing divide and check, time, then hand the result to the output register.
module lprtr_back
#(
    parameter int NUM_RINGS   = lprtr_pkg::NUM_RINGS_DEF,
    parameter int NUM_FIRINGS = lprtr_pkg::NUM_FIRINGS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lprtr_pkg::item_t                    q_item,
    input  wire logic                                q_valid,
    output logic                                     q_take,
    input  wire logic signed [17:0]                  elev_low,
    input  wire logic [13:0]                         ring_sp,
    input  wire logic [13:0]                         az_step,
    input  wire logic [11:0]                         ring_t,
    input  wire logic [15:0]                         fire_t,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [lprtr_pkg::COORD_W-1:0]     out_x,
    output logic signed [lprtr_pkg::COORD_W-1:0]     out_y,
    output logic signed [lprtr_pkg::COORD_W-1:0]     out_z,
    output logic [lprtr_pkg::INTEN_W-1:0]            out_intensity,
    output logic [lprtr_pkg::RING_W-1:0]             ring_index,
    output logic [lprtr_pkg::FIRING_W-1:0]           firing_index,
    output logic [lprtr_pkg::TIME_W-1:0]             time_ns,
    output logic                                     busy
);
    localparam int W = lprtr_pkg::CORDIC_W;

    lprtr_pkg::state_t st_reg, st_next;
    lprtr_pkg::item_t  it_reg;

    logic [5:0]  cnt_reg;
    // sqrt: 44-bit radicand
    logic [43:0] rad_reg;
    logic [43:0] rem_reg;
    logic [23:0] root_reg;
    // cordic
    logic signed [W-1:0] ca_reg, cb_reg;
    logic signed [lprtr_pkg::ANG_W-1:0] cz_reg;
    logic signed [31:0] elev_reg, az_reg;
    // divide: restoring on magnitude, 34-bit numerator
    logic [33:0] dn_reg;
    logic [33:0] dq_reg;
    logic [34:0] dr_reg;
    logic [14:0] dd_reg;
    logic        dneg_reg;
    logic signed [31:0] ring_reg, fire_reg;
    logic [31:0] ref_az_reg;
    logic        ref_taken_reg, wrapped_reg;
    logic [31:0] t_reg;
    logic        ovalid_reg;

    // output register
    assign empty = !ovalid_reg;
    assign busy  = (st_reg != lprtr_pkg::ST_IDLE) || ovalid_reg;

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            lprtr_pkg::ST_IDLE:
                if (q_valid)
                begin
                    st_next = q_item.keep ? lprtr_pkg::ST_SQRT : lprtr_pkg::ST_IDLE;
                end
            lprtr_pkg::ST_SQRT:     if (cnt_reg == 6'd21) st_next = lprtr_pkg::ST_EL_INIT;
            lprtr_pkg::ST_EL_INIT:  st_next = lprtr_pkg::ST_EL_RUN;
            lprtr_pkg::ST_EL_RUN:
                if (cnt_reg == 6'd20) st_next = lprtr_pkg::ST_RING_DIV;
            lprtr_pkg::ST_RING_DIV: if (cnt_reg == 6'd35) st_next = lprtr_pkg::ST_RING_CHK;
            lprtr_pkg::ST_RING_CHK:
                st_next = (ring_reg < 0 || ring_reg >= NUM_RINGS) ?
                          lprtr_pkg::ST_IDLE : lprtr_pkg::ST_AZ_INIT;
            lprtr_pkg::ST_AZ_INIT:  st_next = lprtr_pkg::ST_AZ_RUN;
            lprtr_pkg::ST_AZ_RUN:
                if (cnt_reg == 6'd20) st_next = lprtr_pkg::ST_FIRE_DIV;
            lprtr_pkg::ST_FIRE_DIV: if (cnt_reg == 6'd35) st_next = lprtr_pkg::ST_FIRE_CHK;
            lprtr_pkg::ST_FIRE_CHK:
                st_next = (fire_reg < 0 || fire_reg >= NUM_FIRINGS) ?
                          lprtr_pkg::ST_IDLE : lprtr_pkg::ST_TIME;
            lprtr_pkg::ST_TIME:     st_next = lprtr_pkg::ST_EMIT;
            lprtr_pkg::ST_EMIT:
                if (!ovalid_reg || pop) st_next = lprtr_pkg::ST_IDLE;
            default: st_next = lprtr_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_take = (st_reg == lprtr_pkg::ST_IDLE);
    end

    // cordic step helpers
    logic signed [W-1:0] sh_a, sh_b;
    logic [4:0] ci;
    assign ci   = cnt_reg[4:0];
    assign sh_a = ca_reg >>> ci;
    assign sh_b = cb_reg >>> ci;

    // sqrt step (digit-by-digit, 2 bits of radicand per cycle)
    logic [43:0] trial;
    logic [43:0] rem_sh;
    assign rem_sh = {rem_reg[41:0], rad_reg[43:42]};
    assign trial  = {18'd0, root_reg, 2'b01};

    // divide step
    logic [34:0] dr_sh;
    assign dr_sh = {dr_reg[33:0], dn_reg[33]};

    // cordic prescale/rotate init values
    logic signed [W-1:0] ia, ib;
    logic signed [lprtr_pkg::ANG_W-1:0] iz;
    logic signed [W-1:0] pa, pb;
    always_comb
    begin
        if (st_reg == lprtr_pkg::ST_EL_INIT)
        begin
            pa = W'({1'b0, root_reg}) <<< 20;
            pb = W'(signed'({it_reg.z, 4'd0})) <<< 20;
        end
        else
        begin
            pa = -(W'(it_reg.x) <<< 20);
            pb = W'(it_reg.y) <<< 20;
        end
        ia = pa;
        ib = pb;
        iz = '0;
        if (pa < 0)
        begin
            if (pb >= 0)
            begin
                ia = pb;
                ib = -pa;
                iz = lprtr_pkg::DEG90_FINE;
            end
            else
            begin
                ia = -pb;
                ib = pa;
                iz = -lprtr_pkg::DEG90_FINE;
            end
        end
    end

    // final angle rounding
    logic signed [31:0] ang_rnd;
    logic [31:0] zmag;
    always_comb
    begin
        zmag = cz_reg[31] ? 32'(-cz_reg) : 32'(cz_reg);
        zmag = (zmag + 32'd128) >> 8;
        ang_rnd = cz_reg[31] ? -signed'(zmag) : signed'(zmag);
    end

    // numerator for each divide
    logic signed [33:0] rnum, fnum_raw, fnum;
    logic [14:0] rsp, fsp;
    logic        wrap_now;
    logic [31:0] ref_use;
    always_comb
    begin
        rsp = (ring_sp == '0) ? 15'd1 : {1'b0, ring_sp};
        fsp = (az_step == '0) ? 15'd1 : {1'b0, az_step};
        rnum = 34'(elev_reg) - 34'(elev_low);
        ref_use = ref_taken_reg ? ref_az_reg : 32'(az_reg);
        fnum_raw = 34'(az_reg) - 34'(signed'(ref_use));
        wrap_now = wrapped_reg || fnum_raw[33];
        fnum = wrap_now ? fnum_raw + 34'(lprtr_pkg::FULL_TURN) : fnum_raw;
    end

    function automatic logic [33:0] mag2(input logic signed [33:0] n);
        logic [33:0] m;
        m = n[33] ? 34'(-n) : 34'(n);
        mag2 = {m[32:0], 1'b0};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= lprtr_pkg::ST_IDLE;
            ovalid_reg    <= 1'b0;
            ref_taken_reg <= 1'b0;
            wrapped_reg   <= 1'b0;
            ref_az_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            st_reg <= st_next;
            // load a new result, or drop the popped one
            if (st_reg == lprtr_pkg::ST_EMIT && (!ovalid_reg || pop))
            begin
                ovalid_reg <= 1'b1;
            end
            else if (pop && ovalid_reg)
            begin
                ovalid_reg <= 1'b0;
            end
            case (st_reg)
                lprtr_pkg::ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (q_valid && q_item.fstart)
                    begin
                        ref_taken_reg <= 1'b0;
                        wrapped_reg   <= 1'b0;
                    end
                end
                lprtr_pkg::ST_SQRT, lprtr_pkg::ST_EL_RUN, lprtr_pkg::ST_AZ_RUN:
                    cnt_reg <= (st_next == st_reg) ? cnt_reg + 6'd1 : '0;
                lprtr_pkg::ST_RING_DIV, lprtr_pkg::ST_FIRE_DIV:
                    cnt_reg <= (st_next == st_reg) ? cnt_reg + 6'd1 : '0;
                lprtr_pkg::ST_AZ_INIT:
                    cnt_reg <= '0;
                lprtr_pkg::ST_FIRE_CHK:
                begin
                    // reference and wrap settle here, whatever the firing check decides
                    if (!ref_taken_reg)
                    begin
                        ref_az_reg    <= az_reg;
                        ref_taken_reg <= 1'b1;
                    end
                    wrapped_reg <= wrap_now;
                end
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (st_reg)
            lprtr_pkg::ST_IDLE:
            begin
                it_reg   <= q_item;
                rad_reg  <= (44'(36'(signed'(q_item.x) * signed'(q_item.x)))
                            + 44'(36'(signed'(q_item.y) * signed'(q_item.y)))) << 8;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            lprtr_pkg::ST_SQRT:
            begin
                if (cnt_reg < 6'd22)
                begin
                    rad_reg <= {rad_reg[41:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[22:0], 1'b0};
                    end
                end
            end
            lprtr_pkg::ST_EL_INIT, lprtr_pkg::ST_AZ_INIT:
            begin
                ca_reg <= ia;
                cb_reg <= ib;
                cz_reg <= iz;
            end
            lprtr_pkg::ST_EL_RUN, lprtr_pkg::ST_AZ_RUN:
            begin
                if (cnt_reg < 6'd20)
                begin
                    if (cb_reg >= 0)
                    begin
                        ca_reg <= ca_reg + sh_b;
                        cb_reg <= cb_reg - sh_a;
                        cz_reg <= cz_reg + lprtr_pkg::atan_fine(ci);
                    end
                    else
                    begin
                        ca_reg <= ca_reg - sh_b;
                        cb_reg <= cb_reg + sh_a;
                        cz_reg <= cz_reg - lprtr_pkg::atan_fine(ci);
                    end
                end
                else
                begin
                    // zero vector only reachable on azimuth with x = y = 0
                    if (st_reg == lprtr_pkg::ST_EL_RUN)
                    begin
                        elev_reg <= ang_rnd;
                        dn_reg   <= '0;
                    end
                    else
                    begin
                        az_reg <= (it_reg.x == '0 && it_reg.y == '0) ? '0 : ang_rnd;
                    end
                    dr_reg <= '0;
                    dq_reg <= '0;
                end
            end
            lprtr_pkg::ST_RING_DIV, lprtr_pkg::ST_FIRE_DIV:
            begin
                if (cnt_reg == 6'd0)
                begin
                    // numerator 2|n| + d, divisor 2d
                    if (st_reg == lprtr_pkg::ST_RING_DIV)
                    begin
                        dn_reg   <= mag2(rnum) + 34'(rsp);
                        dd_reg   <= rsp;
                        dneg_reg <= rnum[33];
                    end
                    else
                    begin
                        dn_reg   <= mag2(fnum) + 34'(fsp);
                        dd_reg   <= fsp;
                        dneg_reg <= fnum[33];
                    end
                    dr_reg <= '0;
                    dq_reg <= '0;
                end
                else if (cnt_reg <= 6'd34)
                begin
                    dn_reg <= {dn_reg[32:0], 1'b0};
                    if (dr_sh >= {19'd0, dd_reg, 1'b0})
                    begin
                        dr_reg <= dr_sh - {19'd0, dd_reg, 1'b0};
                        dq_reg <= {dq_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg <= dr_sh;
                        dq_reg <= {dq_reg[32:0], 1'b0};
                    end
                end
            end
            lprtr_pkg::ST_RING_CHK:
            begin
                ring_reg <= ring_reg;
            end
            lprtr_pkg::ST_TIME:
            begin
                t_reg <= 32'(ring_reg[6:0]) * 32'(ring_t)
                       + 32'(fire_reg[11:0]) * 32'(fire_t);
            end
            lprtr_pkg::ST_EMIT:
            begin
                if (!ovalid_reg || pop)
                begin
                    out_x         <= it_reg.x;
                    out_y         <= it_reg.y;
                    out_z         <= it_reg.z;
                    out_intensity <= it_reg.inten;
                    ring_index    <= ring_reg[lprtr_pkg::RING_W-1:0];
                    firing_index  <= fire_reg[lprtr_pkg::FIRING_W-1:0];
                    time_ns       <= t_reg[lprtr_pkg::TIME_W-1:0];
                end
            end
            default:
            begin
                dn_reg <= dn_reg;
            end
        endcase
        // capture quotient once all 34 steps are in
        if (st_reg == lprtr_pkg::ST_RING_DIV && cnt_reg == 6'd35)
        begin
            ring_reg <= dneg_reg ? -signed'(dq_reg[31:0]) : signed'(dq_reg[31:0]);
        end
        if (st_reg == lprtr_pkg::ST_FIRE_DIV && cnt_reg == 6'd35)
        begin
            fire_reg <= dneg_reg ? -signed'(dq_reg[31:0]) : signed'(dq_reg[31:0]);
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/lidar_point_ring_time_recover_core.sv
// Point time recovery for a spinning lidar sweep.
// Input channel: a queue port (push/full). Each transaction carries x, y, z,
// intensity, coord_valid and frame_start. Output channel: a queue port
// (empty/pop); the oldest result is on the result ports while empty is low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; writes are
// taken at any time and must be made while the block is idle.
// A dropped point yields no result. A kept point occupies the sequencer for
// these steps: take it, sqrt, elevation CORDIC, ring divide and check,
// azimuth CORDIC, firing divide and check, time and emit. Each CORDIC pass
// has an init and a run step; each restoring divide loads, makes 34 steps
// and captures. A point with invalid or zero coordinates is dropped as it is
// taken, one failing the ring check after the ring divide, and one failing
// the firing check after the firing divide. One shared sequencer works on
// one point at a time and takes a new point only once the last is through.
// A two-entry input queue lets the sender run ahead by two points.
// Reset clears the queues, the sweep reference and the wrap flag and loads
// the configuration defaults. If the receiver stalls, the finished result
// holds in the output register, the next point waits at the emit step, and
// full rises once the input queue fills.
`default_nettype none
module lidar_point_ring_time_recover_core
#(
    parameter int NUM_RINGS   = lprtr_pkg::NUM_RINGS_DEF,
    parameter int NUM_FIRINGS = lprtr_pkg::NUM_FIRINGS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic signed [lprtr_pkg::COORD_W-1:0]  x_pos,
    input  wire logic signed [lprtr_pkg::COORD_W-1:0]  y_pos,
    input  wire logic signed [lprtr_pkg::COORD_W-1:0]  z_pos,
    input  wire logic [lprtr_pkg::INTEN_W-1:0]         intensity,
    input  wire logic                                  coord_valid,
    input  wire logic                                  frame_start,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lprtr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lprtr_pkg::CFG_DAT_W-1:0]       cfg_data,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic signed [lprtr_pkg::COORD_W-1:0]       out_x,
    output logic signed [lprtr_pkg::COORD_W-1:0]       out_y,
    output logic signed [lprtr_pkg::COORD_W-1:0]       out_z,
    output logic [lprtr_pkg::INTEN_W-1:0]              out_intensity,
    output logic [lprtr_pkg::RING_W-1:0]               ring_index,
    output logic [lprtr_pkg::FIRING_W-1:0]             firing_index,
    output logic [lprtr_pkg::TIME_W-1:0]               time_ns
);
    lprtr_pkg::item_t q_item;
    logic q_valid, q_take, busy;
    logic signed [17:0] elev_low_reg;
    logic [13:0] ring_sp_reg, az_step_reg;
    logic [11:0] ring_t_reg;
    logic [15:0] fire_t_reg;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elev_low_reg <= -18'sd15000;
            ring_sp_reg  <= 14'd2000;
            az_step_reg  <= 14'd200;
            ring_t_reg   <= 12'd2304;
            fire_t_reg   <= 16'd55296;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lprtr_pkg::CFG_ELEV_LOW: elev_low_reg <= signed'(cfg_data);
                lprtr_pkg::CFG_RING_SP:  ring_sp_reg  <= cfg_data[13:0];
                lprtr_pkg::CFG_AZ_STEP:  az_step_reg  <= cfg_data[13:0];
                lprtr_pkg::CFG_RING_T:   ring_t_reg   <= cfg_data[11:0];
                lprtr_pkg::CFG_FIRE_T:   fire_t_reg   <= cfg_data[15:0];
                default: ring_t_reg <= ring_t_reg;
            endcase
        end
    end

    lprtr_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .x_pos(x_pos), .y_pos(y_pos), .z_pos(z_pos), .intensity(intensity),
        .coord_valid(coord_valid), .frame_start(frame_start),
        .q_item(q_item), .q_valid(q_valid), .q_take(q_take)
    );

    lprtr_back #(.NUM_RINGS(NUM_RINGS), .NUM_FIRINGS(NUM_FIRINGS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_item(q_item), .q_valid(q_valid),
        .q_take(q_take), .elev_low(elev_low_reg), .ring_sp(ring_sp_reg),
        .az_step(az_step_reg), .ring_t(ring_t_reg), .fire_t(fire_t_reg),
        .empty(empty), .pop(pop), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .out_intensity(out_intensity), .ring_index(ring_index),
        .firing_index(firing_index), .time_ns(time_ns), .busy(busy)
    );

    // a result appears only after the back part has been busy
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(!empty) |-> $past(busy))
        else $error("result without work");
    // full only when the queue holds a waiting item
    a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_valid)
        else $error("full with empty queue");
    // a held result stays until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(time_ns)))
        else $error("result lost");
endmodule
`default_nettype wire

// File: verif/tb_lidar_point_ring_time_recover_core.sv
`timescale 1ns / 1ps
`default_nettype none

class point_time_scoreboard;
    // Configuration copy
    logic signed [17:0] elev_low;
    logic [13:0] ring_sp;
    logic [13:0] az_step;
    logic [11:0] ring_t;
    logic [15:0] fire_t;
    // Sweep state
    longint az_ref;
    bit ref_valid;
    bit wrap_seen;
    // Pending results: x, y, z, intensity, ring, firing, time
    logic [17:0] q_x[$];
    logic [17:0] q_y[$];
    logic [17:0] q_z[$];
    logic [7:0] q_int[$];
    logic [3:0] q_ring[$];
    logic [10:0] q_fire[$];
    logic [26:0] q_time[$];
    int errors;

    function new();
        elev_low = -18'sd15000;
        ring_sp = 2000;
        az_step = 200;
        ring_t = 2304;
        fire_t = 55296;
        az_ref = 0;
        ref_valid = 0;
        wrap_seen = 0;
        errors = 0;
    endfunction

    function void set_reg(int idx, logic [17:0] val);
        case (idx)
            lprtr_pkg::CFG_ELEV_LOW: elev_low = val;
            lprtr_pkg::CFG_RING_SP:  ring_sp = val[13:0];
            lprtr_pkg::CFG_AZ_STEP:  az_step = val[13:0];
            lprtr_pkg::CFG_RING_T:   ring_t = val[11:0];
            lprtr_pkg::CFG_FIRE_T:   fire_t = val[15:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return q_x.size();
    endfunction

    // Arithmetic shift right, rounding toward minus infinity
    function longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function longint int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC angle of (a, b) in millidegrees
    function longint vec_angle(longint b, longint a);
        longint acc, t, da, db;
        if (a == 0 && b == 0)
            return 0;
        acc = 0;
        a = a * 1048576;
        b = b * 1048576;
        if (a < 0)
        begin
            t = a;
            if (b >= 0)
            begin
                a = b;
                b = -t;
                acc = 23040000;
            end
            else
            begin
                a = -b;
                b = t;
                acc = -23040000;
            end
        end
        for (int i = 0; i < 20; i++)
        begin
            da = shr_floor(b, i);
            db = shr_floor(a, i);
            if (b >= 0)
            begin
                a += da;
                b -= db;
                acc += longint'(lprtr_pkg::atan_fine(i[4:0]));
            end
            else
            begin
                a -= da;
                b += db;
                acc -= longint'(lprtr_pkg::atan_fine(i[4:0]));
            end
        end
        if (acc >= 0)
            return (acc + 128) / 256;
        return -((-acc + 128) / 256);
    endfunction

    function longint div_round(longint n, longint d);
        longint m, q;
        m = n < 0 ? -n : n;
        q = (2 * m + d) / (2 * d);
        return n < 0 ? -q : q;
    endfunction

    // Note an accepted point and queue its expected result, if any
    function void note_point(logic signed [17:0] px, logic signed [17:0] py,
                             logic signed [17:0] pz, logic [7:0] pi,
                             bit pvalid, bit pstart);
        longint x, y, z, r16, elev, ring, az, delta, firing, sp, st;
        longint unsigned tm;
        x = px;
        y = py;
        z = pz;
        if (pstart)
        begin
            ref_valid = 0;
            wrap_seen = 0;
        end
        if (!pvalid || (x == 0 && y == 0 && z == 0))
            return;
        r16 = int_sqrt(longint'(x * x + y * y) << 8);
        elev = vec_angle(z * 16, r16);
        sp = ring_sp ? ring_sp : 1;
        ring = div_round(elev - longint'(elev_low), sp);
        if (ring < 0 || ring >= 16)
            return;
        az = vec_angle(y, -x);
        if (!ref_valid)
        begin
            az_ref = az;
            ref_valid = 1;
        end
        delta = az - az_ref;
        if (delta < 0)
            wrap_seen = 1;
        if (wrap_seen)
            delta += 360000;
        st = az_step ? az_step : 1;
        firing = div_round(delta, st);
        if (firing < 0 || firing >= 1824)
            return;
        tm = ring * ring_t + firing * fire_t;
        q_x = {q_x, px};
        q_y = {q_y, py};
        q_z = {q_z, pz};
        q_int = {q_int, pi};
        q_ring = {q_ring, ring[3:0]};
        q_fire = {q_fire, firing[10:0]};
        q_time = {q_time, tm[26:0]};
    endfunction

    function void check_field(string nm, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, nm, exp_v, act_v);
            errors++;
        end
    endfunction

    // Compare one popped result with the oldest expectation
    function void check_result(logic [17:0] ox, logic [17:0] oy, logic [17:0] oz,
                               logic [7:0] oi, logic [3:0] orng, logic [10:0] ofr,
                               logic [26:0] otm);
        if (q_x.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual x=%0d ring=%0d",
                     $time, ox, orng);
            errors++;
            return;
        end
        check_field("out_x", q_x.pop_front(), ox);
        check_field("out_y", q_y.pop_front(), oy);
        check_field("out_z", q_z.pop_front(), oz);
        check_field("out_intensity", q_int.pop_front(), oi);
        check_field("ring_index", q_ring.pop_front(), orng);
        check_field("firing_index", q_fire.pop_front(), ofr);
        check_field("time_ns", q_time.pop_front(), otm);
    endfunction
endclass

module tb_lidar_point_ring_time_recover_core;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_POINTS = 800;
    localparam int DRAIN_CYCLES = 600;

    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic full;
    logic signed [17:0] x_pos = 0;
    logic signed [17:0] y_pos = 0;
    logic signed [17:0] z_pos = 0;
    logic [7:0] intensity = 0;
    logic coord_valid = 0;
    logic frame_start = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [lprtr_pkg::CFG_IDX_W-1:0] cfg_index = 0;
    logic [lprtr_pkg::CFG_DAT_W-1:0] cfg_data = 0;
    logic empty;
    logic pop = 0;
    logic signed [17:0] out_x;
    logic signed [17:0] out_y;
    logic signed [17:0] out_z;
    logic [7:0] out_intensity;
    logic [3:0] ring_index;
    logic [10:0] firing_index;
    logic [26:0] time_ns;

    point_time_scoreboard sb;
    bit idle_off = 0;
    bit hold_pop = 0;
    int quiet_cycles = 0;

    lidar_point_ring_time_recover_core dut (.*);

    always #2 clk = ~clk;

    // Count cycles without any transaction
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Check results on pop transactions
    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check_result(out_x, out_y, out_z, out_intensity, ring_index,
                            firing_index, time_ns);

    // Drive pop with random stall bursts, plus holds requested by the stimulus
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pop)
                pop <= 0;
            else if (!idle_off && $urandom_range(0, 5) == 0)
            begin
                pop <= 0;
                gap = $urandom_range(1, 7);
                repeat (gap - 1) @(negedge clk);
            end
            else
                pop <= 1;
        end
    end

    task automatic write_reg(input logic [lprtr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [17:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // Offer one point and hold it until accepted
    task automatic send_point(input logic signed [17:0] px, input logic signed [17:0] py,
                              input logic signed [17:0] pz, input logic [7:0] pi,
                              input bit pv, input bit ps);
        if (!idle_off && $urandom_range(0, 5) == 0)
        begin
            push <= 0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        push <= 1;
        x_pos <= px;
        y_pos <= py;
        z_pos <= pz;
        intensity <= pi;
        coord_valid <= pv;
        frame_start <= ps;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_point(px, py, pz, pi, pv, ps);
        @(negedge clk);
    endtask

    // Wait for all results, then let the block finish dropped work
    task automatic drain();
        push <= 0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Point on a ring and at an azimuth given in millidegrees
    task automatic send_aimed(input int ring, input int az_mdeg, input bit ps,
                              input logic signed [17:0] elow, input int sp);
        real el, az, r;
        el = (elow + ring * sp) * 3.14159265358979 / 180000.0;
        az = az_mdeg * 3.14159265358979 / 180000.0;
        r = 20000.0 + $urandom_range(0, 60000);
        send_point(18'(-$rtoi(r * $cos(el) * $cos(az))),
                   18'($rtoi(r * $cos(el) * $sin(az))),
                   18'($rtoi(r * $sin(el))), 8'($urandom), 1, ps);
    endtask

    task automatic random_phase(input int n);
        int az;
        az = 0;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: send_point(18'($urandom), 18'($urandom), 18'($urandom), 8'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                1: send_point(0, 0, 0, 8'($urandom), 1, 0);
                default:
                begin
                    if ($urandom_range(0, 30) == 0)
                        az = 0;
                    else
                        az += $urandom_range(0, 2000);
                    send_aimed($urandom_range(0, 15), az % 360000 - 180000 +
                               ($urandom_range(0, 1) ? 0 : 90000),
                               az == 0, sb.elev_low, sb.ring_sp);
                end
            endcase
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (2) @(negedge clk);

        // Directed: extremes, drops, zero vectors, wrap and frame start
        send_point(18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 8'hFF, 1, 1);
        send_point(-18'sd131072, -18'sd131072, -18'sd131072, 8'h00, 1, 0);
        send_point(0, 0, 0, 8'h55, 1, 0);
        send_point(0, 0, 1000, 8'hAA, 1, 0);
        send_point(1000, 0, 0, 8'h01, 0, 0);
        send_point(-30000, 0, -5000, 8'h10, 1, 1);
        send_point(-30000, 500, -5000, 8'h11, 1, 0);
        send_point(-30000, -500, -5000, 8'h12, 1, 0);
        send_point(-30000, 1000, -5000, 8'h13, 1, 0);
        send_point(30000, 1, 0, 8'h14, 1, 0);
        send_point(30000, -1, 0, 8'h15, 1, 1);
        send_point(0, 30000, 100, 8'h16, 1, 0);
        send_point(0, -30000, 100, 8'h17, 1, 0);
        send_point(-131072, 0, 0, 8'h18, 1, 1);
        send_point(-20000, 0, 20000, 8'h19, 1, 0);
        drain();

        // Receiver holds off while the sender fills the block
        hold_pop = 1;
        fork
            begin
                repeat (2000) @(posedge clk);
                hold_pop = 0;
            end
            random_phase(12);
        join

        // Default-ish settings with random stimulus
        write_reg(lprtr_pkg::CFG_RING_T, 12'd4095);
        write_reg(lprtr_pkg::CFG_FIRE_T, 16'd65535);
        random_phase(200);

        // Extreme settings
        write_reg(lprtr_pkg::CFG_ELEV_LOW, -18'sd90000);
        write_reg(lprtr_pkg::CFG_RING_SP, 14'd10000);
        write_reg(lprtr_pkg::CFG_AZ_STEP, 14'd10000);
        write_reg(lprtr_pkg::CFG_RING_T, 12'd0);
        write_reg(lprtr_pkg::CFG_FIRE_T, 16'd0);
        random_phase(150);

        write_reg(lprtr_pkg::CFG_ELEV_LOW, 18'sd0);
        write_reg(lprtr_pkg::CFG_RING_SP, 14'd1);
        write_reg(lprtr_pkg::CFG_AZ_STEP, 14'd1);
        write_reg(lprtr_pkg::CFG_RING_T, 12'd1234);
        write_reg(lprtr_pkg::CFG_FIRE_T, 16'd777);
        random_phase(150);

        // Zero steps act as one; all-ones widths
        write_reg(lprtr_pkg::CFG_ELEV_LOW, -18'sd3000);
        write_reg(lprtr_pkg::CFG_RING_SP, 14'd0);
        write_reg(lprtr_pkg::CFG_AZ_STEP, 14'h3FFF);
        random_phase(100);

        write_reg(lprtr_pkg::CFG_ELEV_LOW, -18'sd15000);
        write_reg(lprtr_pkg::CFG_RING_SP, 14'd2000);
        write_reg(lprtr_pkg::CFG_AZ_STEP, 14'd0);
        write_reg(lprtr_pkg::CFG_RING_T, 12'd2304);
        write_reg(lprtr_pkg::CFG_FIRE_T, 16'd55296);
        random_phase(100);

        // Last part with no idling
        write_reg(lprtr_pkg::CFG_AZ_STEP, 14'd200);
        idle_off = 1;
        random_phase(100);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire
